FILE: hw/rtl/sadpcm_pkg.sv
// sadpcm_pkg: shared types, state codes and coefficient functions
// for the sound adpcm block decoder; no dependencies
package sadpcm_pkg;

	localparam int unsigned SampleW = 16;
	localparam int unsigned CoefW   = 8;
	localparam int unsigned ProdW   = SampleW + CoefW;
	localparam int unsigned SumW    = SampleW + 3;
	localparam int unsigned CoefSh  = 6;

	localparam logic [3:0] PosHeader = 4'd0;
	localparam logic [3:0] PosFlags  = 4'd1;
	localparam logic [3:0] PosLast   = 4'd15;
	localparam logic [3:0] PredMax   = 4'd4;

	localparam logic signed [SampleW-1:0] SatMax = 16'sh7fff;
	localparam logic signed [SampleW-1:0] SatMin = 16'sh8000;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_sound;
	} in_item_t;

	typedef struct packed {
		logic signed [SampleW-1:0] first_sample;
		logic signed [SampleW-1:0] second_sample;
		logic                      block_end;
		logic                      loop_end_flag;
		logic                      loop_repeat_flag;
		logic                      loop_start_flag;
		logic                      bad_predictor;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL0,
		ST_ADD0,
		ST_MUL1,
		ST_ADD1,
		ST_OUT
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic mul;
		logic add;
		logic nib_sel;
		logic load_out;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_data;
		logic out_free;
	} dp_sts_t;

	// weight on the newer sample; predictors above four decode as zero
	function automatic logic signed [CoefW-1:0] coef_newer(input logic [3:0] pred);
		logic signed [CoefW-1:0] c;
		case (pred)
			4'd1:    c = 8'sd60;
			4'd2:    c = 8'sd115;
			4'd3:    c = 8'sd98;
			4'd4:    c = 8'sd122;
			default: c = 8'sd0;
		endcase
		return c;
	endfunction

	// weight on the older sample
	function automatic logic signed [CoefW-1:0] coef_older(input logic [3:0] pred);
		logic signed [CoefW-1:0] c;
		case (pred)
			4'd2:    c = -8'sd52;
			4'd3:    c = -8'sd55;
			4'd4:    c = -8'sd60;
			default: c = 8'sd0;
		endcase
		return c;
	endfunction

endpackage

FILE: hw/rtl/sound_adpcm_block_decoder_top.sv
// sound_adpcm_block_decoder_top: top level of the sound adpcm block decoder
// instantiates sadpcm_ctrl and sadpcm_dp; depends on sadpcm_pkg
//
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    in_data   (in_item_t)
// out       output     out_valid / out_ready  out_data  (out_item_t)
//
// header and flags bytes are each accepted in the idle state and produce no transfer on out
// a data byte steps through accept, then multiply and add for the low
// nibble, then for the high nibble, then the load into the output register
// the add of each nibble needs the sample that the previous nibble produced
// a stalled out channel holds the decoder in its final step until the slot frees
// arst_n clears history, block position and header state, and empties the output
module sound_adpcm_block_decoder_top import sadpcm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequencer: one item in flight, steps the datapath through both nibbles
	sadpcm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: header state, predictor multiply, saturating add, output register
	sadpcm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

FILE: hw/rtl/sadpcm_dp.sv
// sadpcm_dp: block header state, two-tap predictor datapath and output register
// depends on sadpcm_pkg
module sadpcm_dp import sadpcm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  dp_cmd_t   cmd,
	output dp_sts_t   sts,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic [3:0] pos_q;
	logic [3:0] shift_q;
	logic [3:0] pred_q;
	logic [7:0] flags_q;
	logic signed [SampleW-1:0] newer_q;
	logic signed [SampleW-1:0] older_q;
	logic signed [SampleW-1:0] first_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       out_valid_q;
	out_item_t  out_q;

	logic signed [SampleW-1:0] val_s1;
	logic signed [ProdW-1:0]   prod0_s1;
	logic signed [ProdW-1:0]   prod1_s1;

	logic [3:0]                pos_eff;
	logic [3:0]                nib;
	logic signed [SampleW-1:0] nib_top;
	logic signed [SumW-1:0]    sum;
	logic signed [SampleW-1:0] sat;

	// start of sound restarts the block
	assign pos_eff = in_data.start_of_sound ? PosHeader : pos_q;

	assign sts.is_data  = (pos_eff != PosHeader) && (pos_eff != PosFlags);
	assign sts.out_free = !out_valid_q || out_ready;

	assign nib     = cmd.nib_sel ? byte_q[7:4] : byte_q[3:0];
	assign nib_top = {nib, 12'b0};

	always_comb begin
		sum = SumW'(val_s1) + SumW'(prod0_s1 >>> CoefSh) + SumW'(prod1_s1 >>> CoefSh);
		if (sum > SumW'(SatMax)) begin
			sat = SatMax;
		end else if (sum < SumW'(SatMin)) begin
			sat = SatMin;
		end else begin
			sat = sum[SampleW-1:0];
		end
	end

	// header state and history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			shift_q <= '0;
			pred_q  <= '0;
			flags_q <= '0;
			newer_q <= '0;
			older_q <= '0;
		end else begin
			if (cmd.accept) begin
				pos_q <= pos_eff + 4'd1;
				if (in_data.start_of_sound) begin
					newer_q <= '0;
					older_q <= '0;
				end
				if (pos_eff == PosHeader) begin
					shift_q <= in_data.data_byte[3:0];
					pred_q  <= in_data.data_byte[7:4];
				end else if (pos_eff == PosFlags) begin
					flags_q <= in_data.data_byte;
				end
			end
			if (cmd.add) begin
				older_q <= newer_q;
				newer_q <= sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			byte_q <= in_data.data_byte;
			last_q <= (pos_eff == PosLast);
		end
		if (cmd.mul) begin
			val_s1   <= nib_top >>> shift_q;
			prod0_s1 <= newer_q * coef_newer(pred_q);
			prod1_s1 <= older_q * coef_older(pred_q);
		end
		if (cmd.add && !cmd.nib_sel) begin
			first_q <= sat;
		end
		if (cmd.load_out) begin
			out_q.first_sample     <= first_q;
			out_q.second_sample    <= newer_q;
			out_q.block_end        <= last_q;
			out_q.loop_end_flag    <= flags_q[0];
			out_q.loop_repeat_flag <= flags_q[1];
			out_q.loop_start_flag  <= flags_q[2];
			out_q.bad_predictor    <= (pred_q > PredMax);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_load_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken result");

	a_history_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!cmd.accept && !cmd.add) |=> $stable(newer_q) && $stable(older_q))
		else $error("history changed with no byte or add step");

	a_restart_position: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && in_data.start_of_sound) |=> (pos_q == PosFlags))
		else $error("start of sound did not restart the block position");

endmodule

FILE: hw/rtl/sadpcm_ctrl.sv
// sadpcm_ctrl: sequencer for one data byte, two nibbles of multiply then add
// depends on sadpcm_pkg
module sadpcm_ctrl import sadpcm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid && sts.is_data) begin
					state_d = ST_MUL0;
				end
			end
			ST_MUL0: begin
				cmd.mul = 1'b1;
				state_d = ST_ADD0;
			end
			ST_ADD0: begin
				cmd.add = 1'b1;
				state_d = ST_MUL1;
			end
			ST_MUL1: begin
				cmd.mul     = 1'b1;
				cmd.nib_sel = 1'b1;
				state_d     = ST_ADD1;
			end
			ST_ADD1: begin
				cmd.add     = 1'b1;
				cmd.nib_sel = 1'b1;
				state_d     = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_data_starts_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && sts.is_data) |=> (state_q == ST_MUL0))
		else $error("data byte did not start the decode sequence");

	a_header_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !sts.is_data) |=> (state_q == ST_IDLE))
		else $error("header or flags byte started a decode");

	a_add_follows_mul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul |=> cmd.add && $stable(cmd.nib_sel))
		else $error("multiply step not followed by its add step");

endmodule
